[src/bcgc_pkg.sv]
`timescale 1ns / 1ps

package bcgc_pkg;

    localparam int CELLS_MAX   = 4;
    localparam int CELLS_DEF   = 4;
    localparam int CELL_W      = 16;
    localparam int VOLTS_W     = CELLS_MAX * CELL_W;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 14;
    localparam int CUR_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELL_MV        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERVOLT_HOLD_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_RELEASE_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DEGLITCH_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_ALERT_MS   = 3'd5;

    // Register reset values
    localparam logic                  RST_CHARGE_ENABLE      = 1'b1;
    localparam logic [CELL_W-1:0]     RST_MAX_CELL_MV        = 16'd4200;
    localparam logic [TIME_W-1:0]     RST_OVERVOLT_HOLD_MS   = 32'd20000;
    localparam logic [LEVEL_W-1:0]    RST_FULL_RELEASE_LEVEL = 14'd9500;
    localparam logic [TIME_W-1:0]     RST_FULL_DEGLITCH_MS   = 32'd5000;
    localparam logic [TIME_W-1:0]     RST_STARTUP_ALERT_MS   = 32'd500;

    // Charger chip report codes
    localparam logic [2:0] REP_UNINIT     = 3'd0;
    localparam logic [2:0] REP_COMP_ERROR = 3'd1;
    localparam logic [2:0] REP_FAULTS     = 3'd2;
    localparam logic [2:0] REP_OFF        = 3'd3;
    localparam logic [2:0] REP_FAST       = 3'd4;
    localparam logic [2:0] REP_SLOW       = 3'd5;

    typedef enum logic [3:0] {
        ST_UNINIT     = 4'd0,
        ST_INACTIVE   = 4'd1,
        ST_POWER      = 4'd2,
        ST_SLOW       = 4'd3,
        ST_CHARGING   = 4'd4,
        ST_FINISHED   = 4'd5,
        ST_NO_BATTERY = 4'd6,
        ST_SW_ERROR   = 4'd7,
        ST_HW_ERROR   = 4'd8
    } charger_state_t;

    typedef enum logic [1:0] {
        ALERT_NONE  = 2'd0,
        ALERT_RAISE = 2'd1,
        ALERT_CLEAR = 2'd2
    } alert_t;

    typedef struct packed {
        logic                      charge_enable;
        logic [CELL_W-1:0]         max_cell_mv;
        logic [TIME_W-1:0]         overvolt_hold_ms;
        logic [LEVEL_W-1:0]        full_release_level;
        logic [TIME_W-1:0]         full_deglitch_ms;
        logic [TIME_W-1:0]         startup_alert_ms;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]         now_ms;
        logic                      charge_ok_pin;
        logic                      otg_active;
        logic                      balancer_valid;
        logic [VOLTS_W-1:0]        cell_voltages;
        logic                      source_usable;
        logic                      vbus_power;
        logic                      measure_valid;
        logic                      battery_present;
        logic [LEVEL_W-1:0]        battery_level;
        logic signed [CUR_W-1:0]   charge_current_ma;
        logic [2:0]                ic_report;
    } item_t;

    typedef struct packed {
        logic                      charge_on;
        charger_state_t            status;
        alert_t                    alert_action;
        logic                      full_latched;
        logic                      clear_faults;
    } result_t;

endpackage

[src/bcgc_if.sv]
`timescale 1ns / 1ps

interface bcgc_in_if;
    logic                valid;
    logic                ready;
    logic [31:0]         now_ms;
    logic                charge_ok_pin;
    logic                otg_active;
    logic                balancer_valid;
    logic [63:0]         cell_voltages;
    logic                source_usable;
    logic                vbus_power;
    logic                measure_valid;
    logic                battery_present;
    logic [13:0]         battery_level;
    logic signed [15:0]  charge_current_ma;
    logic [2:0]          ic_report;

    modport source (
        output valid, now_ms, charge_ok_pin, otg_active, balancer_valid, cell_voltages,
               source_usable, vbus_power, measure_valid, battery_present, battery_level,
               charge_current_ma, ic_report,
        input  ready
    );

    modport sink (
        input  valid, now_ms, charge_ok_pin, otg_active, balancer_valid, cell_voltages,
               source_usable, vbus_power, measure_valid, battery_present, battery_level,
               charge_current_ma, ic_report,
        output ready
    );
endinterface

interface bcgc_out_if;
    logic        valid;
    logic        ready;
    logic        charge_on;
    logic [3:0]  status;
    logic [1:0]  alert_action;
    logic        full_latched;
    logic        clear_faults;

    modport source (
        output valid, charge_on, status, alert_action, full_latched, clear_faults,
        input  ready
    );

    modport sink (
        input  valid, charge_on, status, alert_action, full_latched, clear_faults,
        output ready
    );
endinterface

[src/battery_charge_gate_controller_unit.sv]
`timescale 1ns / 1ps

// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the whole tick, all cell lanes and the merge
// are combinational, and the output register takes a new beat whenever it is
// empty or being drained.
// Reset (rst_n low, asynchronous): config registers return to their defaults,
// the full latch and both timer stamps clear, the output register empties.
module battery_charge_gate_controller_unit #(
    parameter int CELLS = bcgc_pkg::CELLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bcgc_in_if.sink                         in_ch,
    bcgc_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [bcgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bcgc_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    accept;

    // Accept a new tick whenever the output register is free or draining this cycle.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Gather the input beat into one struct for the gate.
    always_comb
    begin
        item.now_ms            = in_ch.now_ms;
        item.charge_ok_pin     = in_ch.charge_ok_pin;
        item.otg_active        = in_ch.otg_active;
        item.balancer_valid    = in_ch.balancer_valid;
        item.cell_voltages     = in_ch.cell_voltages;
        item.source_usable     = in_ch.source_usable;
        item.vbus_power        = in_ch.vbus_power;
        item.measure_valid     = in_ch.measure_valid;
        item.battery_present   = in_ch.battery_present;
        item.battery_level     = in_ch.battery_level;
        item.charge_current_ma = in_ch.charge_current_ma;
        item.ic_report         = in_ch.ic_report;
    end

    // Configuration registers: write by index, ignore indexes past the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_enable      <= RST_CHARGE_ENABLE;
            cfg_reg.max_cell_mv        <= RST_MAX_CELL_MV;
            cfg_reg.overvolt_hold_ms   <= RST_OVERVOLT_HOLD_MS;
            cfg_reg.full_release_level <= RST_FULL_RELEASE_LEVEL;
            cfg_reg.full_deglitch_ms   <= RST_FULL_DEGLITCH_MS;
            cfg_reg.startup_alert_ms   <= RST_STARTUP_ALERT_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHARGE_ENABLE:      cfg_reg.charge_enable      <= cfg_wdata[0];
                CFG_MAX_CELL_MV:        cfg_reg.max_cell_mv        <= cfg_wdata[CELL_W-1:0];
                CFG_OVERVOLT_HOLD_MS:   cfg_reg.overvolt_hold_ms   <= cfg_wdata[TIME_W-1:0];
                CFG_FULL_RELEASE_LEVEL: cfg_reg.full_release_level <= cfg_wdata[LEVEL_W-1:0];
                CFG_FULL_DEGLITCH_MS:   cfg_reg.full_deglitch_ms   <= cfg_wdata[TIME_W-1:0];
                CFG_STARTUP_ALERT_MS:   cfg_reg.startup_alert_ms   <= cfg_wdata[TIME_W-1:0];
                default:
                begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // Cell lanes, merge and charge gate; state advances only on an accepted beat.
    bcgc_gate #(
        .CELLS (CELLS)
    ) u_gate (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .cfg     (cfg_reg),
        .item    (item),
        .result  (result)
    );

    // Output register: load on accept, hold while the sink stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.charge_on    = out_reg.charge_on;
    assign out_ch.status       = out_reg.status;
    assign out_ch.alert_action = out_reg.alert_action;
    assign out_ch.full_latched = out_reg.full_latched;
    assign out_ch.clear_faults = out_reg.clear_faults;

endmodule

[src/bcgc_cell_lane.sv]
`timescale 1ns / 1ps

module bcgc_cell_lane (
    input  logic [bcgc_pkg::CELL_W-1:0] cell_mv,
    input  logic [bcgc_pkg::CELL_W-1:0] limit_mv,
    output logic                        over
);
    import bcgc_pkg::*;

    // flag a cell at or above the limit
    assign over = (cell_mv >= limit_mv);

endmodule

[src/bcgc_gate.sv]
`timescale 1ns / 1ps

module bcgc_gate #(
    parameter int CELLS = bcgc_pkg::CELLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  bcgc_pkg::cfg_t    cfg,
    input  bcgc_pkg::item_t   item,
    output bcgc_pkg::result_t result
);
    import bcgc_pkg::*;

    logic [CELLS-1:0]  lane_over;
    logic              any_over;

    logic              full_latch_reg;
    logic              full_latch_next;
    logic [TIME_W-1:0] ov_stamp_reg;
    logic [TIME_W-1:0] ov_stamp_next;
    logic [TIME_W-1:0] dg_stamp_reg;
    logic [TIME_W-1:0] dg_stamp_next;

    logic              latch_base;
    charger_state_t    status;
    logic              err;
    logic              on;
    logic [TIME_W-1:0] ov_elapsed;
    logic [TIME_W-1:0] dg_elapsed;
    logic              ov_holding;
    logic              eoc;

    // one compare lane per cell
    for (genvar g = 0; g < CELLS; g++) begin : g_lane
        bcgc_cell_lane u_lane (
            .cell_mv  (item.cell_voltages[g*CELL_W +: CELL_W]),
            .limit_mv (cfg.max_cell_mv),
            .over     (lane_over[g])
        );
    end

    // merge the lanes
    assign any_over   = |lane_over;

    assign ov_elapsed = item.now_ms - ov_stamp_reg;
    assign dg_elapsed = item.now_ms - dg_stamp_reg;
    assign ov_holding = (ov_stamp_reg != '0) && (ov_elapsed < cfg.overvolt_hold_ms);

    always_comb
    begin
        latch_base = full_latch_reg & ~item.otg_active;

        unique case (item.ic_report)
            REP_UNINIT:     status = ST_SW_ERROR;
            REP_COMP_ERROR: status = ST_HW_ERROR;
            REP_FAULTS:     status = ST_SW_ERROR;
            REP_OFF:
            begin
                if (!item.battery_present)
                    status = ST_NO_BATTERY;
                else
                    status = item.vbus_power ? ST_POWER : ST_INACTIVE;
            end
            REP_FAST:       status = latch_base ? ST_FINISHED : ST_CHARGING;
            REP_SLOW:       status = ST_SLOW;
            default:        status = ST_SW_ERROR;
        endcase

        err = (status == ST_UNINIT) || (status == ST_HW_ERROR) ||
              (status == ST_SW_ERROR) || (status == ST_NO_BATTERY);

        eoc = (item.charge_current_ma <= $signed(CUR_W'(0))) && (status == ST_CHARGING);

        full_latch_next = latch_base;
        ov_stamp_next   = ov_stamp_reg;
        dg_stamp_next   = dg_stamp_reg;
        on              = 1'b0;

        if (!err && item.charge_ok_pin)
        begin
            if (!cfg.charge_enable || item.otg_active || !item.balancer_valid)
            begin
                // blocked: stamps hold; the latch holds unless OTG is active
            end
            else if (any_over)
            begin
                ov_stamp_next = item.now_ms;
            end
            else if (ov_holding)
            begin
                // still inside the hold window
            end
            else
            begin
                ov_stamp_next = '0;
                if (!item.source_usable)
                begin
                    // source not usable
                end
                else if (!item.vbus_power)
                begin
                    full_latch_next = 1'b0;
                end
                else if (!item.measure_valid)
                begin
                    // measurements stale
                end
                else if (!item.battery_present)
                begin
                    full_latch_next = 1'b0;
                end
                else if (latch_base)
                begin
                    if (item.battery_level < cfg.full_release_level)
                        full_latch_next = 1'b0;
                end
                else if (eoc)
                begin
                    if (dg_stamp_reg == '0)
                    begin
                        dg_stamp_next = item.now_ms;
                        on            = 1'b1;
                    end
                    else if (dg_elapsed > cfg.full_deglitch_ms)
                    begin
                        dg_stamp_next   = '0;
                        full_latch_next = 1'b1;
                    end
                    else
                    begin
                        on = 1'b1;
                    end
                end
                else
                begin
                    dg_stamp_next = '0;
                    on            = 1'b1;
                end
            end
        end

        result.charge_on    = on;
        result.status       = status;
        result.alert_action = err ? ((item.now_ms >= cfg.startup_alert_ms) ? ALERT_RAISE
                                                                           : ALERT_NONE)
                                  : ALERT_CLEAR;
        result.full_latched = full_latch_next;
        result.clear_faults = (item.ic_report == REP_FAULTS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_latch_reg <= 1'b0;
            ov_stamp_reg   <= '0;
            dg_stamp_reg   <= '0;
        end
        else if (advance)
        begin
            full_latch_reg <= full_latch_next;
            ov_stamp_reg   <= ov_stamp_next;
            dg_stamp_reg   <= dg_stamp_next;
        end
    end

endmodule
